>>> hw/rtl/clt_pkg.sv
// Package for the command line tokenizer: byte classes, escape codes and the
// queue entry type shared by the front, the queue and the back.
// No dependencies.
package clt_pkg;

  // Byte codes that the tokenizer treats specially.
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // Register address map: one word, at byte address 0.
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MAX_ARGS = 1'b0;
  localparam logic [7:0] MAX_ARGS_RESET = 8'd16;

  // Class of an incoming byte, worked out in the front.
  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_NUL    = 3'd1,
    CLS_BLANK  = 3'd2,
    CLS_NL     = 3'd3,
    CLS_QUOTE  = 3'd4,
    CLS_BSLASH = 3'd5
  } char_cls_t;

  // Pending escape: none, inside quotes, or outside quotes.
  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_QUOTED = 2'd1,
    ESC_PLAIN  = 2'd2
  } esc_t;

  // One queue entry: the byte and its class.
  typedef struct packed {
    char_cls_t  cls;
    logic [7:0] ch;
  } item_t;

endpackage

>>> hw/rtl/command_line_tokenizer.sv
// Command line tokenizer: one line byte in, one result word out per byte.
// A result is valid once its byte has passed the front stage register, the
// queue and the back output register. Throughput: one byte per cycle while
// out_ready holds, as the tokenizer step in the back is combinational.
// Synchronous active-low reset clears the line state, empties the queue and
// sets max_args to 16.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
module command_line_tokenizer #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [clt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_char_in,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_write_valid,
  output logic [7:0]                 out_write_byte,
  output logic [7:0]                 out_write_pos,
  output logic                       out_arg_done,
  output logic [7:0]                 out_arg_start,
  output logic [7:0]                 out_arg_count,
  output logic                       out_line_done,
  output logic                       out_line_overflow
);

  logic [7:0]     max_args_r;
  logic           cfg_wr;
  logic           push_valid, push_ready;
  clt_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  clt_pkg::item_t pop_item;

  // Register write and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == clt_pkg::REG_MAX_ARGS);
  assign prdata = (paddr[2] == clt_pkg::REG_MAX_ARGS) ? {24'd0, max_args_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r <= clt_pkg::MAX_ARGS_RESET;
    end else if (cfg_wr) begin
      max_args_r <= pwdata[7:0];
    end
  end

  // Front: accept and classify.
  clt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue between front and back.
  clt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: tokenizer state and results.
  clt_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .max_args          (max_args_r),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_item          (pop_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_valid   (out_write_valid),
    .out_write_byte    (out_write_byte),
    .out_write_pos     (out_write_pos),
    .out_arg_done      (out_arg_done),
    .out_arg_start     (out_arg_start),
    .out_arg_count     (out_arg_count),
    .out_line_done     (out_line_done),
    .out_line_overflow (out_line_overflow)
  );

endmodule

>>> hw/rtl/clt_front.sv
// Front of the command line tokenizer: accepts bytes and classifies them.
// Depends on clt_pkg.
module clt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char_in,
  output logic           push_valid,
  input  logic           push_ready,
  output clt_pkg::item_t push_item
);

  logic           stage_valid_r;
  logic           stage_valid_nxt;
  clt_pkg::item_t stage_item_r;
  clt_pkg::item_t cls_item;
  logic           accept;

  // The stage takes a new word whenever it is empty or its word moves on.
  assign in_ready   = !stage_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = stage_valid_r;
  assign push_item  = stage_item_r;

  // Classify the incoming byte.
  always_comb begin
    cls_item.ch = in_char_in;
    case (in_char_in)
      clt_pkg::CHAR_NUL:    cls_item.cls = clt_pkg::CLS_NUL;
      clt_pkg::CHAR_TAB:    cls_item.cls = clt_pkg::CLS_BLANK;
      clt_pkg::CHAR_SPACE:  cls_item.cls = clt_pkg::CLS_BLANK;
      clt_pkg::CHAR_NL:     cls_item.cls = clt_pkg::CLS_NL;
      clt_pkg::CHAR_QUOTE:  cls_item.cls = clt_pkg::CLS_QUOTE;
      clt_pkg::CHAR_BSLASH: cls_item.cls = clt_pkg::CLS_BSLASH;
      default:              cls_item.cls = clt_pkg::CLS_OTHER;
    endcase
  end

  // Stage valid flag.
  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (push_ready) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item_r <= cls_item;
    end
  end

endmodule

>>> hw/rtl/clt_queue.sv
// Short queue between the front and the back of the command line tokenizer.
// Depends on clt_pkg.
module clt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  clt_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output clt_pkg::item_t pop_item
);

  clt_pkg::item_t                         mem_r [clt_pkg::QUEUE_DEPTH];
  logic [clt_pkg::QUEUE_PTR_W-1:0]        wr_ptr_r;
  logic [clt_pkg::QUEUE_PTR_W-1:0]        rd_ptr_r;
  logic [clt_pkg::QUEUE_CNT_W-1:0]        count_r;
  logic [clt_pkg::QUEUE_CNT_W-1:0]        count_nxt;
  logic                                   do_push;
  logic                                   do_pop;

  assign push_ready = (count_r != clt_pkg::QUEUE_CNT_W'(clt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/clt_back.sv
// Back of the command line tokenizer: line state, argument bookkeeping and
// the output register. Depends on clt_pkg.
module clt_back #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     max_args,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  clt_pkg::item_t pop_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_write_valid,
  output logic [7:0]     out_write_byte,
  output logic [7:0]     out_write_pos,
  output logic           out_arg_done,
  output logic [7:0]     out_arg_start,
  output logic [7:0]     out_arg_count,
  output logic           out_line_done,
  output logic           out_line_overflow
);

  localparam int unsigned POS_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned EXT_W = (POS_W > 8) ? POS_W : 8;

  logic                quoted_r, quoted_nxt;
  clt_pkg::esc_t       esc_r, esc_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]    in_pos_r, in_pos_nxt;
  logic [POS_W-1:0]    start_r, start_nxt;
  logic [7:0]          args_r, args_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                wv, done, ldone, ovf;
  logic [7:0]          wb;
  logic [EXT_W-1:0]    wpos_ext, astart_ext;
  logic [7:0]          count_out;
  logic                do_pop;

  logic                write_valid_r;
  logic [7:0]          write_byte_r;
  logic [7:0]          write_pos_r;
  logic                arg_done_r;
  logic [7:0]          arg_start_r;
  logic [7:0]          arg_count_r;
  logic                line_done_r;
  logic                line_overflow_r;

  // A word is taken when the output register is empty or being emptied.
  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  // Tokenizer step for the word at the head of the queue.
  always_comb begin
    quoted_nxt  = quoted_r;
    esc_nxt     = esc_r;
    out_pos_nxt = out_pos_r;
    in_pos_nxt  = in_pos_r;
    start_nxt   = start_r;
    args_nxt    = args_r;
    wv          = 1'b0;
    wb          = 8'd0;
    done        = 1'b0;
    ldone       = 1'b0;
    ovf         = 1'b0;

    if (in_pos_r >= POS_W'(LINE_BYTES)) begin
      // The line is full: drop the byte and end the line.
      ldone = 1'b1;
      ovf   = 1'b1;
    end else begin
      in_pos_nxt = in_pos_r + 1'b1;
      if (pop_item.cls == clt_pkg::CLS_NUL) begin
        ldone = 1'b1;
      end else if (esc_r != clt_pkg::ESC_NONE) begin
        // Escaped byte is kept as it is, but a continuation writes nothing.
        esc_nxt = clt_pkg::ESC_NONE;
        if (!(esc_r == clt_pkg::ESC_PLAIN && pop_item.cls == clt_pkg::CLS_NL)) begin
          wv = 1'b1;
          wb = pop_item.ch;
        end
      end else if (quoted_r) begin
        case (pop_item.cls)
          clt_pkg::CLS_BSLASH: esc_nxt    = clt_pkg::ESC_QUOTED;
          clt_pkg::CLS_QUOTE:  quoted_nxt = 1'b0;
          default: begin
            wv = 1'b1;
            wb = pop_item.ch;
          end
        endcase
      end else begin
        case (pop_item.cls)
          clt_pkg::CLS_BLANK, clt_pkg::CLS_NL: begin
            if (out_pos_r != start_r && args_r < max_args) begin
              wv       = 1'b1;
              done     = 1'b1;
              args_nxt = args_r + 1'b1;
            end
            ldone = (pop_item.cls == clt_pkg::CLS_NL);
          end
          clt_pkg::CLS_QUOTE:  quoted_nxt = 1'b1;
          clt_pkg::CLS_BSLASH: esc_nxt    = clt_pkg::ESC_PLAIN;
          default: begin
            wv = 1'b1;
            wb = pop_item.ch;
          end
        endcase
      end
      if (wv) begin
        out_pos_nxt = out_pos_r + 1'b1;
        if (done) begin
          start_nxt = out_pos_r + 1'b1;
        end
      end
    end

    wpos_ext   = wv ? EXT_W'(out_pos_r) : '0;
    astart_ext = done ? EXT_W'(start_r) : '0;
    count_out  = args_nxt;

    // A finished line clears all line state.
    if (ldone) begin
      quoted_nxt  = 1'b0;
      esc_nxt     = clt_pkg::ESC_NONE;
      out_pos_nxt = '0;
      in_pos_nxt  = '0;
      start_nxt   = '0;
      args_nxt    = 8'd0;
    end
  end

  // Output valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Line state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoted_r    <= 1'b0;
      esc_r       <= clt_pkg::ESC_NONE;
      out_pos_r   <= '0;
      in_pos_r    <= '0;
      start_r     <= '0;
      args_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (do_pop) begin
        quoted_r  <= quoted_nxt;
        esc_r     <= esc_nxt;
        out_pos_r <= out_pos_nxt;
        in_pos_r  <= in_pos_nxt;
        start_r   <= start_nxt;
        args_r    <= args_nxt;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      write_valid_r   <= wv;
      write_byte_r    <= wb;
      write_pos_r     <= wpos_ext[7:0];
      arg_done_r      <= done;
      arg_start_r     <= astart_ext[7:0];
      arg_count_r     <= count_out;
      line_done_r     <= ldone;
      line_overflow_r <= ovf;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = write_valid_r;
  assign out_write_byte    = write_byte_r;
  assign out_write_pos     = write_pos_r;
  assign out_arg_done      = arg_done_r;
  assign out_arg_start     = arg_start_r;
  assign out_arg_count     = arg_count_r;
  assign out_line_done     = line_done_r;
  assign out_line_overflow = line_overflow_r;

endmodule
